// ----- rtl/tasgs_pkg.sv -----
// Package for the three-axis servo gait stepper: shared types, codes and gait tables.
// No dependencies.
package tasgs_pkg;

    localparam logic [1:0] OP_MOVE = 2'd0;
    localparam logic [1:0] OP_FWD  = 2'd1;
    localparam logic [1:0] OP_BWD  = 2'd2;

    localparam logic [11:0] DWELL_MAX = 12'd4095;
    localparam logic [7:0]  POS_RESET = 8'd90;
    localparam logic [7:0]  SPEED_RESET = 8'd20;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

    // Target table lookup: joint 0 mount, 1 hip, 2 knee; bwd selects backward gait.
    function automatic logic [7:0] gait_target(input logic bwd, input logic [1:0] joint,
                                               input logic [1:0] row, input logic [1:0] stage);
        logic [1:0] r;
        logic       alt;
        logic [7:0] v;
        begin
            r = row;
            v = 8'd90;
            case (joint)
                2'd0: begin
                    alt = r[0] ^ bwd;
                    case (stage)
                        2'd0: v = 8'd90;
                        2'd1: v = alt ? 8'd135 : 8'd45;
                        2'd2: v = alt ? 8'd135 : 8'd45;
                        default: v = alt ? 8'd45 : 8'd135;
                    endcase
                end
                2'd1: begin
                    alt = r[1] ^ bwd;
                    case (stage)
                        2'd0: v = 8'd60;
                        2'd1: v = alt ? 8'd30 : 8'd115;
                        2'd2: v = alt ? 8'd60 : 8'd135;
                        default: v = 8'd95;
                    endcase
                end
                default: begin
                    alt = r[1] ^ bwd;
                    case (stage)
                        2'd0: v = alt ? 8'd50 : 8'd100;
                        2'd1: v = alt ? 8'd45 : 8'd145;
                        2'd2: v = alt ? 8'd45 : 8'd145;
                        default: v = alt ? 8'd145 : 8'd50;
                    endcase
                end
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/tasgs_ctrl.sv -----
// Controller state machine of the servo gait stepper.
// Depends on tasgs_pkg.
module tasgs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_fire,
    input  logic                i_out_busy,
    input  tasgs_pkg::t_status  i_status,
    output tasgs_pkg::t_cmd     o_cmd,
    output logic                o_idle
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV1  = 3'd1;
    localparam logic [2:0] S_WAIT1 = 3'd2;
    localparam logic [2:0] S_DIV2  = 3'd3;
    localparam logic [2:0] S_WAIT2 = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = 2'd0;
                n_state = S_WAIT1;
            end
            S_WAIT1: begin
                o_cmd.div_sel = 2'd0;
                if (i_status.div_done) n_state = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = 2'd1;
                n_state = S_WAIT2;
            end
            S_WAIT2: begin
                o_cmd.div_sel = 2'd1;
                if (i_status.div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/tasgs_dp.sv -----
// Datapath of the servo gait stepper: positions, skip counters, ceiling divider, dwell.
// Depends on tasgs_pkg.
module tasgs_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tasgs_pkg::t_cmd     i_cmd,
    output tasgs_pkg::t_status  o_status,
    input  logic [1:0]          i_orientation,
    input  logic [7:0]          i_servo_speed,
    input  logic [1:0]          i_opcode,
    input  logic [7:0]          i_mount_target,
    input  logic [7:0]          i_hip_target,
    input  logic [7:0]          i_knee_target,
    input  logic                i_sync,
    input  logic [7:0]          i_speed_mod,
    input  logic [2:0]          i_leg_count,
    output logic [41:0]         o_result
);

    logic [7:0]  r_pos [3];
    logic [7:0]  r_skip [3];
    logic [1:0]  r_stage;
    logic [7:0]  r_tgt [3];
    logic        r_sync, r_gait;
    logic [11:0] r_dwell;
    logic [7:0]  r_dist [3];
    logic [1:0]  r_lead;
    logic [7:0]  r_ratio [2];

    logic [7:0]  r_rem, r_den;
    logic [8:0]  r_quo;
    logic [3:0]  r_cnt;
    logic        r_busy;

    logic [1:0]  fidx [2];
    logic [7:0]  tgt_c [3];
    logic [15:0] prod;
    logic [7:0]  mult;
    logic [11:0] dwell_c;
    logic [7:0]  dist_c [3];
    logic [1:0]  lead_c;
    logic [8:0]  num;

    always_comb begin
        fidx[0] = (r_lead == 2'd0) ? 2'd1 : 2'd0;
        fidx[1] = (r_lead == 2'd2) ? 2'd1 : 2'd2;
    end

    always_comb begin
        mult = 8'd0;
        prod = 16'd0;
        for (int j = 0; j < 3; j++) begin
            tgt_c[j] = tasgs_pkg::gait_target(i_opcode == tasgs_pkg::OP_BWD, 2'(j),
                                              i_orientation, r_stage);
        end
        if (i_opcode == tasgs_pkg::OP_FWD) begin
            if (r_stage == 2'd3) begin
                mult = (i_leg_count == 3'd0) ? 8'd0
                     : 8'({5'd0, i_leg_count} * 8'd3 - 8'd3);
            end else begin
                mult = 8'd1;
            end
            prod = i_servo_speed * mult;
        end else if (i_opcode == tasgs_pkg::OP_BWD) begin
            prod = {8'd0, i_servo_speed};
        end else begin
            tgt_c[0] = i_mount_target;
            tgt_c[1] = i_hip_target;
            tgt_c[2] = i_knee_target;
            prod = (i_servo_speed * i_speed_mod) >> 4;
        end
        dwell_c = (prod > 16'(tasgs_pkg::DWELL_MAX)) ? tasgs_pkg::DWELL_MAX : prod[11:0];
        for (int j = 0; j < 3; j++) begin
            dist_c[j] = (r_pos[j] > tgt_c[j]) ? r_pos[j] - tgt_c[j] : tgt_c[j] - r_pos[j];
        end
        if (dist_c[0] >= dist_c[1] && dist_c[0] >= dist_c[2]) lead_c = 2'd0;
        else if (dist_c[1] >= dist_c[2]) lead_c = 2'd1;
        else lead_c = 2'd2;
    end

    // Restoring divider computes ceil(lead/own) as (lead+own-1)/own, one bit per cycle.
    assign num = {1'b0, r_dist[r_lead]} + {1'b0, r_dist[fidx[i_cmd.div_sel[0]]]} - 9'd1;
    assign o_status.div_done = r_busy && (r_cnt == 4'd0);

    logic [8:0] trial;
    assign trial = {r_rem, r_quo[8]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 4'd0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_cnt <= 4'd9;
            r_rem <= 8'd0;
            r_quo <= num;
            r_den <= r_dist[fidx[i_cmd.div_sel[0]]];
        end else if (r_busy) begin
            if (r_cnt == 4'd0) begin
                r_busy <= 1'b0;
                r_ratio[i_cmd.div_sel[0]] <= r_quo[7:0];
            end else begin
                r_cnt <= r_cnt - 4'd1;
                if (!trial[8]) begin
                    r_rem <= trial[7:0];
                    r_quo <= {r_quo[7:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[6:0], r_quo[8]};
                    r_quo <= {r_quo[7:0], 1'b0};
                end
            end
        end
    end

    // The quotient of a zero divisor is never used, and it stays below 256 when own<lead.
    logic       en [3];
    logic [7:0] skip_n [3];
    logic [7:0] pos_n [3];
    logic       rdy [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            en[j] = 1'b1;
            skip_n[j] = r_skip[j];
        end
        if (r_sync) begin
            for (int k = 0; k < 2; k++) begin
                if (r_dist[fidx[k]] < r_dist[r_lead] && r_dist[fidx[k]] != 8'd0) begin
                    if ({1'b0, r_skip[fidx[k]]} + 9'd1 >= {1'b0, r_ratio[k]}) begin
                        skip_n[fidx[k]] = 8'd0;
                    end else begin
                        skip_n[fidx[k]] = r_skip[fidx[k]] + 8'd1;
                        en[fidx[k]] = 1'b0;
                    end
                end
            end
        end
        for (int j = 0; j < 3; j++) begin
            rdy[j] = (r_pos[j] == r_tgt[j]);
            if (r_tgt[j] > r_pos[j]) pos_n[j] = r_pos[j] + 8'(en[j]);
            else if (r_tgt[j] < r_pos[j]) pos_n[j] = r_pos[j] - 8'(en[j]);
            else pos_n[j] = r_pos[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int j = 0; j < 3; j++) begin
                r_tgt[j] <= tgt_c[j];
                r_dist[j] <= dist_c[j];
            end
            r_lead <= lead_c;
            r_sync <= (i_opcode == tasgs_pkg::OP_FWD) ||
                      ((i_opcode != tasgs_pkg::OP_BWD) && i_sync);
            r_gait <= (i_opcode == tasgs_pkg::OP_FWD) || (i_opcode == tasgs_pkg::OP_BWD);
            r_dwell <= dwell_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_pos[j] <= tasgs_pkg::POS_RESET;
                r_skip[j] <= 8'd0;
            end
            r_stage <= 2'd0;
        end else if (i_cmd.commit) begin
            for (int j = 0; j < 3; j++) begin
                r_pos[j] <= pos_n[j];
                r_skip[j] <= skip_n[j];
            end
            if (r_gait && rdy[0] && rdy[1] && rdy[2]) r_stage <= r_stage + 2'd1;
        end
    end

    assign o_result = {r_stage, r_dwell, rdy[0] & rdy[1] & rdy[2], rdy[2], rdy[1], rdy[0],
                       pos_n[2], pos_n[1], pos_n[0]};

endmodule

// ----- rtl/three_axis_servo_gait_stepper_top.sv -----
// Top level of the three-axis servo gait stepper: stream ports, APB registers, output register.
// Depends on tasgs_pkg, tasgs_ctrl and tasgs_dp.
//
// Each accepted input transfer is one servo tick and yields one result transfer. Targets,
// distances and dwell are captured at the accepting edge; then the controller starts the shared
// 9-step ceiling divider for the first following joint, waits for it, starts it again for the
// second, waits, and commits, registering the result in the output register. One item is
// processed at a time: a new item is accepted from the cycle after the commit, and the
// commit waits while an earlier result still sits unaccepted in the output register.
module three_axis_servo_gait_stepper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], mount_target[9:2], hip_target[17:10], knee_target[25:18], sync[26],
    // speed_mod[34:27], leg_count[37:35], zero fill to 40 bits.
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mount_angle[7:0], hip_angle[15:8], knee_angle[23:16], mount_ready[24], hip_ready[25],
    // knee_ready[26], leg_ready[27], dwell_ticks[39:28], gait_stage_out[41:40], zero fill.
    output logic [47:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  r_orientation;
    logic [7:0]  r_servo_speed;
    logic        r_out_valid;
    logic [41:0] r_out_data;
    logic        in_fire, idle;
    logic [41:0] result;
    tasgs_pkg::t_cmd    cmd;
    tasgs_pkg::t_status status;

    assign pready = 1'b1;
    assign s_axis_tready = idle;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orientation <= 2'd0;
            r_servo_speed <= tasgs_pkg::SPEED_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr == 3'd0) r_orientation <= pwdata[1:0];
            else if (paddr == 3'd4) r_servo_speed <= pwdata[7:0];
        end
    end

    always_comb begin
        case (paddr)
            3'd0: prdata = {30'd0, r_orientation};
            3'd4: prdata = {24'd0, r_servo_speed};
            default: prdata = 32'd0;
        endcase
    end

    tasgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_busy (r_out_valid && !m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    // The datapath samples the stream word directly at acceptance.
    tasgs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_orientation  (r_orientation),
        .i_servo_speed  (r_servo_speed),
        .i_opcode       (s_axis_tdata[1:0]),
        .i_mount_target (s_axis_tdata[9:2]),
        .i_hip_target   (s_axis_tdata[17:10]),
        .i_knee_target  (s_axis_tdata[25:18]),
        .i_sync         (s_axis_tdata[26]),
        .i_speed_mod    (s_axis_tdata[34:27]),
        .i_leg_count    (s_axis_tdata[37:35]),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.commit) r_out_data <= result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {6'd0, r_out_data};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !s_axis_tready)
        else $error("input accepted during processing");
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("commit without output valid");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !cmd.commit)
        else $error("result overwritten");

endmodule
